// ===== sv/fpp_pkg.sv =====
package fpp_pkg;

  localparam int unsigned MAX_FRAME_PACKETS = 512;
  localparam int unsigned NS_PER_WINDOW     = 1000000;
  localparam int unsigned MIN_LIMIT         = 32;
  localparam int unsigned RESULT_CAP        = 64;

  localparam int unsigned COUNT_W  = 10;
  localparam int unsigned OFFSET_W = 9;
  localparam int unsigned TIME_W   = 63;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned LIMIT_W  = 10;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned NRES_W   = 6;

  // NS_PER_WINDOW * MAX_FRAME_PACKETS fits in 29 bits; one quotient bit per step
  localparam int unsigned NUM_W     = 29;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned DCNT_W    = 5;

  localparam logic [CFG_IDX_W-1:0] REG_PACING_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PACKETS_PER_MS = 2'd2;

  localparam logic [LIMIT_W-1:0] BATCH_LIMIT_RST    = 10'd64;
  localparam logic [RATE_W-1:0]  PACKETS_PER_MS_RST = 16'd1000;

  typedef struct packed {
    logic [COUNT_W-1:0] packet_count;
    logic [TIME_W-1:0]  now_ns;
  } in_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] batch_offset;
    logic [COUNT_W-1:0]  batch_count;
    logic [TIME_W-1:0]   due_ns;
    logic                last_batch;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic plan;
    logic div_step;
    logic cap_due;
    logic load_end;
    logic cap_end;
    logic emit;
    logic emit_direct;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic direct;
    logic last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/fpp_ctrl.sv =====
module fpp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fpp_pkg::sts_t sts_i,
  output fpp_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_DIRECT  = 3'd2;
  localparam logic [2:0] S_PLAN    = 3'd3;
  localparam logic [2:0] S_DIV_DUE = 3'd4;
  localparam logic [2:0] S_DIV_END = 3'd5;
  localparam logic [2:0] S_EMIT    = 3'd6;

  logic [2:0]                   state_q, state_d;
  logic [fpp_pkg::DCNT_W-1:0]   cnt_q, cnt_d;
  logic                         div_done;

  assign div_done   = (cnt_q == fpp_pkg::DCNT_W'(fpp_pkg::DIV_STEPS));
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.empty) begin
          state_d = S_IDLE;
        end else if (sts_i.direct) begin
          state_d = S_DIRECT;
        end else begin
          state_d = S_PLAN;
        end
      end
      S_DIRECT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_direct = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_PLAN: begin
        cmd_o.plan = 1'b1;
        cnt_d      = '0;
        state_d    = S_DIV_DUE;
      end
      S_DIV_DUE: begin
        if (!div_done) begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + 1'b1;
        end else begin
          cmd_o.cap_due = 1'b1;
          if (sts_i.last) begin
            // end time of the frame is needed before the final batch leaves
            cmd_o.load_end = 1'b1;
            cnt_d          = '0;
            state_d        = S_DIV_END;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_DIV_END: begin
        if (!div_done) begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + 1'b1;
        end else begin
          cmd_o.cap_end = 1'b1;
          state_d       = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.last ? S_IDLE : S_PLAN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== sv/fpp_datapath.sv =====
module fpp_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fpp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fpp_pkg::CFG_W-1:0]         cfg_data_i,
  input  fpp_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output fpp_pkg::out_item_t                out_data_o,
  input  fpp_pkg::cmd_t                     cmd_i,
  output fpp_pkg::sts_t                     sts_o
);

  localparam int unsigned CW = fpp_pkg::COUNT_W;
  localparam int unsigned TW = fpp_pkg::TIME_W;
  localparam int unsigned RW = fpp_pkg::RATE_W;
  localparam int unsigned NW = fpp_pkg::NUM_W;

  // configuration
  logic                        pacing_q;
  logic [fpp_pkg::LIMIT_W-1:0] limit_q;
  logic [RW-1:0]               rate_q;
  logic [fpp_pkg::LIMIT_W-1:0] limit_eff;
  logic [RW-1:0]               rate_eff;

  // frame state
  logic [TW-1:0]               frame_end_q;
  logic [CW-1:0]               total_q;
  logic [TW-1:0]               now_q;
  logic [TW-1:0]               start_q;
  logic [CW-1:0]               sent_q;
  logic [RW-1:0]               inwin_q;
  logic [fpp_pkg::NRES_W-1:0]  nres_q;
  logic [CW-1:0]               take_q;
  logic                        wait_q;
  logic                        last_q;
  logic [TW-1:0]               due_q;
  logic [TW-1:0]               end_q;

  // divider
  logic [NW-1:0]               num_q;
  logic [RW-1:0]               rem_q;
  logic [RW:0]                 trial;
  logic                        trial_ge;
  logic [RW:0]                 trial_sub;

  logic [CW-1:0]               in_total;
  logic [TW-1:0]               in_start;
  logic [RW-1:0]               budget;
  logic [CW-1:0]               remain;
  logic [RW-1:0]               take_w;
  logic [CW-1:0]               take_n;
  logic                        wait_n;
  logic                        last_n;
  logic [CW-1:0]               sent_plus;
  logic [NW-1:0]               num_due;
  logic [NW-1:0]               num_end;
  logic [TW:0]                 due_sum;
  logic [TW-1:0]               due_sat;

  logic                        out_valid_q;
  fpp_pkg::out_item_t          out_q;

  assign limit_eff = (limit_q < fpp_pkg::LIMIT_W'(fpp_pkg::MIN_LIMIT))
                     ? fpp_pkg::LIMIT_W'(fpp_pkg::MIN_LIMIT) : limit_q;
  assign rate_eff  = (rate_q < RW'(fpp_pkg::MIN_LIMIT)) ? RW'(fpp_pkg::MIN_LIMIT) : rate_q;

  assign in_total = (in_data_i.packet_count > CW'(fpp_pkg::MAX_FRAME_PACKETS))
                    ? CW'(fpp_pkg::MAX_FRAME_PACKETS) : in_data_i.packet_count;
  assign in_start = (frame_end_q > in_data_i.now_ns) ? frame_end_q : in_data_i.now_ns;

  // batch planning
  assign budget = rate_eff - inwin_q;
  assign remain = total_q - sent_q;
  assign wait_n = (budget == '0);
  always_comb begin
    take_w = RW'(remain);
    if (take_w > budget) begin
      take_w = budget;
    end
    if (take_w > RW'(limit_eff)) begin
      take_w = RW'(limit_eff);
    end
  end
  assign take_n    = wait_n ? '0 : CW'(take_w);
  assign last_n    = (!wait_n && ((sent_q + take_n) == total_q))
                     || (nres_q == fpp_pkg::NRES_W'(fpp_pkg::RESULT_CAP - 1));
  assign sent_plus = sent_q + take_q;
  assign num_due   = NW'(fpp_pkg::NS_PER_WINDOW * 32'(sent_q));
  assign num_end   = NW'(fpp_pkg::NS_PER_WINDOW * 32'(sent_plus));

  // restoring division, one quotient bit a step; quotient shifts into num_q
  assign trial     = {rem_q, num_q[NW-1]};
  assign trial_ge  = (trial >= {1'b0, rate_eff});
  assign trial_sub = trial - {1'b0, rate_eff};

  // start plus offset, saturating at the top of the 63-bit range
  assign due_sum = {1'b0, start_q} + (TW+1)'(num_q);
  assign due_sat = due_sum[TW] ? {TW{1'b1}} : due_sum[TW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pacing_q    <= 1'b0;
      limit_q     <= fpp_pkg::BATCH_LIMIT_RST;
      rate_q      <= fpp_pkg::PACKETS_PER_MS_RST;
      frame_end_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fpp_pkg::REG_PACING_ENABLED: pacing_q <= cfg_data_i[0];
          fpp_pkg::REG_BATCH_LIMIT:    limit_q  <= cfg_data_i[fpp_pkg::LIMIT_W-1:0];
          fpp_pkg::REG_PACKETS_PER_MS: rate_q   <= cfg_data_i[RW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.emit && last_q) begin
        frame_end_q <= end_q;
      end
      if (cmd_i.emit || cmd_i.emit_direct) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      total_q <= in_total;
      now_q   <= in_data_i.now_ns;
      start_q <= in_start;
      sent_q  <= '0;
      inwin_q <= '0;
      nres_q  <= '0;
    end
    if (cmd_i.plan) begin
      take_q <= take_n;
      wait_q <= wait_n;
      last_q <= last_n;
      num_q  <= num_due;
      rem_q  <= '0;
    end else if (cmd_i.load_end) begin
      num_q <= num_end;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[NW-2:0], trial_ge};
      rem_q <= trial_ge ? trial_sub[RW-1:0] : trial[RW-1:0];
    end
    if (cmd_i.cap_due) begin
      due_q <= due_sat;
    end
    if (cmd_i.cap_end) begin
      end_q <= due_sat;
    end
    if (cmd_i.emit) begin
      out_q.batch_offset <= sent_q[fpp_pkg::OFFSET_W-1:0];
      out_q.batch_count  <= take_q;
      out_q.due_ns       <= due_q;
      out_q.last_batch   <= last_q;
      sent_q             <= sent_plus;
      inwin_q            <= wait_q ? '0 : inwin_q + RW'(take_q);
      nres_q             <= nres_q + 1'b1;
    end else if (cmd_i.emit_direct) begin
      out_q.batch_offset <= '0;
      out_q.batch_count  <= total_q;
      out_q.due_ns       <= now_q;
      out_q.last_batch   <= 1'b1;
    end
  end

  assign sts_o.empty    = (total_q == '0);
  assign sts_o.direct   = !pacing_q || (total_q <= limit_eff);
  assign sts_o.last     = last_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/frame_packet_pacer.sv =====
// Frame packet pacer.
// Input channel (in_valid_i / in_stall_o / in_data_i): one request per video
// frame, carrying its packet count and the current time in ns. Output channel
// (out_valid_o / out_stall_i / out_data_o): the frame's send schedule, one
// batch per output item, the final one flagged by last_batch.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 pacing enable, 1 batch limit, 2 packets per ms); write only while idle.
// One frame at a time. An empty frame frees the input after the check state.
// An unpaced frame (or one that fits a batch) goes out whole as one batch
// through the check and direct states. Each batch of a paced frame passes a
// planning step, a 29-step bit-serial divider for the due time, a step adding
// it to the start time and a hand-over step; the final batch needs a second
// division for the frame end time. Up to 64 batches per frame.
// The output register lets the next frame be accepted while the last batch
// still waits. A stalled receiver holds the batch and the sequencer waits.
// Reset restores the register defaults and clears the stored frame end time.
module frame_packet_pacer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fpp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fpp_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  fpp_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output fpp_pkg::out_item_t            out_data_o
);

  fpp_pkg::cmd_t cmd;
  fpp_pkg::sts_t sts;

  fpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fpp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== sv/fpp_checker.sv =====
module fpp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input fpp_pkg::in_item_t             in_data_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input fpp_pkg::out_item_t            out_data_o
);

  // a stalled batch holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled batch changed");

  // one frame at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not held off after accepting a frame");

  // an empty frame frees the input again once it has been checked
  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.packet_count == '0)
    |=> ##1 !in_stall_o)
    else $error("empty frame kept the block busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.batch_count <= fpp_pkg::COUNT_W'(fpp_pkg::MAX_FRAME_PACKETS))
    else $error("batch count beyond frame size");

endmodule

bind frame_packet_pacer fpp_checker u_fpp_checker (.*);

// ===== tb/frame_schedule_checker.sv =====
`timescale 1ns / 100ps

module frame_schedule_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fpp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fpp_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  fpp_pkg::in_item_t             in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  fpp_pkg::out_item_t            out_data_i,
  output int                            errors_o,
  output int                            outstanding_o
);

  localparam logic [fpp_pkg::TIME_W-1:0] TIME_MAX = '1;

  logic                         cfg_pacing;
  logic [fpp_pkg::LIMIT_W-1:0]  cfg_limit;
  logic [fpp_pkg::RATE_W-1:0]   cfg_rate;
  logic [fpp_pkg::TIME_W-1:0]   frame_end;
  fpp_pkg::out_item_t           due_batches[$];
  fpp_pkg::out_item_t           want;
  int                           mismatches;
  int                           waiting;

  assign errors_o      = mismatches;
  assign outstanding_o = waiting;

  // start + window * sent / rate, saturating at the top of the time range
  function automatic logic [fpp_pkg::TIME_W-1:0] due_time(
      logic [fpp_pkg::TIME_W-1:0] start, int unsigned sent, int unsigned rate);
    bit [63:0] off;
    off = (64'(fpp_pkg::NS_PER_WINDOW) * 64'(sent)) / 64'(rate);
    if (off > 64'(TIME_MAX - start)) return TIME_MAX;
    return start + off[fpp_pkg::TIME_W-1:0];
  endfunction

  function automatic void plan_frame_schedule(fpp_pkg::in_item_t req);
    int unsigned                total;
    int unsigned                limit;
    int unsigned                rate;
    int unsigned                sent;
    int unsigned                in_window;
    int unsigned                take;
    int unsigned                n;
    logic [fpp_pkg::TIME_W-1:0] start;
    fpp_pkg::out_item_t         b;
    total = req.packet_count;
    limit = (cfg_limit < fpp_pkg::MIN_LIMIT) ? fpp_pkg::MIN_LIMIT : cfg_limit;
    rate  = (cfg_rate < fpp_pkg::MIN_LIMIT) ? fpp_pkg::MIN_LIMIT : cfg_rate;
    if (total > fpp_pkg::MAX_FRAME_PACKETS) total = fpp_pkg::MAX_FRAME_PACKETS;
    if (total == 0) return;
    if (!cfg_pacing || total <= limit) begin
      b.batch_offset = '0;
      b.batch_count  = fpp_pkg::COUNT_W'(total);
      b.due_ns       = req.now_ns;
      b.last_batch   = 1'b1;
      due_batches    = {due_batches, b};
      return;
    end
    start     = (frame_end > req.now_ns) ? frame_end : req.now_ns;
    sent      = 0;
    in_window = 0;
    n         = 0;
    while (sent < total && n < fpp_pkg::RESULT_CAP) begin
      if (rate == in_window) begin
        // window spent: wait request, fresh window
        take      = 0;
        in_window = 0;
      end else begin
        take = total - sent;
        if (take > rate - in_window) take = rate - in_window;
        if (take > limit) take = limit;
      end
      b.batch_offset = fpp_pkg::OFFSET_W'(sent);
      b.batch_count  = fpp_pkg::COUNT_W'(take);
      b.due_ns       = due_time(start, sent, rate);
      b.last_batch   = (sent + take >= total) || (n + 1 == fpp_pkg::RESULT_CAP);
      due_batches    = {due_batches, b};
      sent      += take;
      in_window += take;
      n++;
    end
    frame_end = due_time(start, sent, rate);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_pacing  = 1'b0;
      cfg_limit   = fpp_pkg::BATCH_LIMIT_RST;
      cfg_rate    = fpp_pkg::PACKETS_PER_MS_RST;
      frame_end   = '0;
      due_batches.delete();
      mismatches  = 0;
      waiting     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fpp_pkg::REG_PACING_ENABLED: cfg_pacing = cfg_data_i[0];
          fpp_pkg::REG_BATCH_LIMIT:    cfg_limit  = cfg_data_i[fpp_pkg::LIMIT_W-1:0];
          fpp_pkg::REG_PACKETS_PER_MS: cfg_rate   = cfg_data_i[fpp_pkg::RATE_W-1:0];
          default: ;
        endcase
      end
      // results first: a batch leaving now never belongs to a frame entering now
      if (out_valid_i && !out_stall_i) begin
        if (due_batches.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected batch: off %0d cnt %0d due %0d last %0b",
                     out_data_i.batch_offset, out_data_i.batch_count,
                     out_data_i.due_ns, out_data_i.last_batch);
        end else begin
          want = due_batches.pop_front();
          if (want !== out_data_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("batch differs: exp off %0d cnt %0d due %0d last %0b, ",
                       want.batch_offset, want.batch_count, want.due_ns,
                       want.last_batch,
                       "got off %0d cnt %0d due %0d last %0b",
                       out_data_i.batch_offset, out_data_i.batch_count,
                       out_data_i.due_ns, out_data_i.last_batch);
          end
        end
      end
      if (in_valid_i && !in_stall_i) plan_frame_schedule(in_data_i);
      waiting = due_batches.size();
    end
  end

endmodule

// ===== tb/tb_frame_packet_pacer.sv =====
`timescale 1ns / 100ps

module tb_frame_packet_pacer;

  localparam logic [fpp_pkg::TIME_W-1:0] TIME_MAX = '1;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [fpp_pkg::CFG_IDX_W-1:0] cfg_idx_i   = fpp_pkg::REG_PACING_ENABLED;
  logic [fpp_pkg::CFG_W-1:0]     cfg_data_i  = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  fpp_pkg::in_item_t             in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  fpp_pkg::out_item_t            out_data_o;
  logic                          quiet       = 1'b0;
  int                            errors;
  int                            outstanding;

  frame_packet_pacer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  frame_schedule_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_i    (out_data_o),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(0, 99) < 6);
  end

  initial begin
    #40_000_000;
    $display("frame_packet_pacer: mismatch");
    $finish;
  end

  function automatic logic [fpp_pkg::TIME_W-1:0] rand_time();
    bit [63:0] r;
    r = {$urandom, $urandom};
    return r[fpp_pkg::TIME_W-1:0];
  endfunction

  task automatic send_frame(input int unsigned count,
                            input logic [fpp_pkg::TIME_W-1:0] now);
    while (!quiet && $urandom_range(0, 99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{packet_count: fpp_pkg::COUNT_W'(count), now_ns: now};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drain all outstanding batches, then let the sequencer finish its tail work
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned pacing, input int unsigned limit,
                            input int unsigned rate);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= fpp_pkg::REG_PACING_ENABLED;
    cfg_data_i <= fpp_pkg::CFG_W'(pacing);
    @(posedge clk_i);
    cfg_idx_i  <= fpp_pkg::REG_BATCH_LIMIT;
    cfg_data_i <= fpp_pkg::CFG_W'(limit);
    @(posedge clk_i);
    cfg_idx_i  <= fpp_pkg::REG_PACKETS_PER_MS;
    cfg_data_i <= fpp_pkg::CFG_W'(rate);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [fpp_pkg::TIME_W-1:0] clock_ns;
    logic [fpp_pkg::TIME_W-1:0] now;
    int unsigned                pacing;
    int unsigned                limit;
    int unsigned                rate;
    int unsigned                count;
    int unsigned                r;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults: pacing off, every frame goes out in one batch
    send_frame(0, '0);
    send_frame(1, '0);
    send_frame(512, TIME_MAX);
    send_frame(1023, rand_time());
    send_frame(700, 63'd12345);
    settle();

    // limits below the floor act as 32
    set_config(1, 0, 0);
    send_frame(32, 63'd1000);
    send_frame(33, 63'd2000);
    send_frame(0, 63'd3000);
    send_frame(512, '0);
    send_frame(1023, 63'd5_000_000_000);
    settle();

    // rate just above the batch size: most requests per frame
    set_config(1, 31, 33);
    send_frame(512, 63'd6_000_000_000);
    send_frame(100, 63'd6_000_000_000);
    settle();

    set_config(1, 512, 65535);
    send_frame(512, 63'd7_000_000_000);
    settle();
    set_config(1, 40, 65535);
    send_frame(512, 63'd7_000_000_000);
    settle();

    clock_ns = (rand_time() >> 23) + 63'd8_000_000_000;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin pacing = 1; limit = 64;  rate = 1000;  end
        1: begin pacing = 1; limit = 32;  rate = 32;    end
        2: begin pacing = 1; limit = 100; rate = 65535; end
        3: begin pacing = 0; limit = 200; rate = 500;   end
        4: begin
          pacing = 1;
          limit  = $urandom_range(32, 512);
          rate   = $urandom_range(32, 2000);
        end
        default: begin
          pacing = 1;
          limit  = $urandom_range(0, 512);
          rate   = $urandom_range(0, 65535);
        end
      endcase
      set_config(pacing, limit, rate);
      quiet <= (ph == 2);
      for (int i = 0; i < 60; i++) begin
        r = $urandom_range(0, 99);
        if (r >= 75) clock_ns += 63'($urandom_range(1_000_001, 20_000_000));
        else if (r >= 25) clock_ns += 63'($urandom_range(1, 1_000_000));
        r = $urandom_range(0, 99);
        if (r < 5) count = 0;
        else if (r < 75) count = $urandom_range(1, 160);
        else if (r < 95) count = $urandom_range(161, 512);
        else count = $urandom_range(513, 1023);
        // full-range times only where the stored end time is left alone
        if (pacing == 0 && $urandom_range(0, 99) < 25) now = rand_time();
        else now = clock_ns;
        send_frame(count, now);
      end
      settle();
    end
    quiet <= 1'b0;

    // time overflow last: the stored end time sticks at the top afterwards
    set_config(1, 32, 32);
    send_frame(100, TIME_MAX - 63'd5000);
    send_frame(512, '0);
    settle();
    repeat (100) @(posedge clk_i);

    if (errors == 0 && outstanding == 0) begin
      $display("frame_packet_pacer: match");
    end else begin
      $display("frame_packet_pacer: mismatch");
    end
    $finish;
  end

endmodule
